>>> hdl/snp_candidate_neighbour_scoring_core_defines.svh
// assertion macros for the snp candidate scoring core
// expects signals clk and arst_n in the scope of use
`ifndef SNP_CANDIDATE_NEIGHBOUR_SCORING_CORE_DEFINES_SVH
`define SNP_CANDIDATE_NEIGHBOUR_SCORING_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SNPCNS_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("snpcns implication violated");
`define SNPCNS_ASSERT_NEVER(lbl, a) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(a)) \
		else $error("snpcns forbidden condition seen");
`else
`define SNPCNS_ASSERT_IMP(lbl, a, c)
`define SNPCNS_ASSERT_NEVER(lbl, a)
`endif
`endif

>>> hdl/snpcns_pkg.sv
// shared types and constants of the snp candidate scoring core
// no dependencies
`timescale 1ns / 1ps
package snpcns_pkg;
	localparam int POS_W = 24;
	localparam int SCORE_W = 20;
	localparam int QS_W = 16;
	localparam int CUT_W = 12;
	localparam int PROD_W = SCORE_W + QS_W;
	localparam int FRAC_W = 8;
	localparam logic [SCORE_W-1:0] CAP_Q = 20'd256000;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;
	localparam int FIFO_CW = 3;
	localparam int DIV_W = 24;
	localparam int DIV_STEP = 4;
	localparam int DIV_CYC = DIV_W / DIV_STEP;
	localparam int CNT_W = 3;
	localparam int COST_W = 4;
	localparam int IDX_W = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_CUTOFF = 2'd0,
		REG_PAIR_MODE = 2'd1,
		REG_START_POS = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_HOLD
	} div_state_t;

	typedef struct packed {
		logic [CUT_W-1:0] cutoff;
		logic pair_mode;
		logic [POS_W-1:0] start_pos;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [SCORE_W-1:0] comb;
		logic f;
		logic last;
		logic [3:0] fd;
		logic [SCORE_W-1:0] sd0;
		logic [SCORE_W-1:0] sd1;
	} rec_t;
endpackage

>>> hdl/snpcns_if.sv
// channel interfaces: score items, scored results, register writes
// depends on snpcns_pkg
`timescale 1ns / 1ps
interface snpcns_item_if;
	logic valid;
	logic ready;
	logic [snpcns_pkg::SCORE_W-1:0] q_primary;
	logic [snpcns_pkg::QS_W-1:0] q_secondary;
	logic region_end;
	modport source (output valid, q_primary, q_secondary, region_end, input ready);
	modport sink (input valid, q_primary, q_secondary, region_end, output ready);
endinterface

interface snpcns_result_if;
	logic valid;
	logic ready;
	logic is_snp;
	logic [snpcns_pkg::POS_W-1:0] snp_pos;
	logic [snpcns_pkg::SCORE_W-1:0] snp_score;
	logic done_res;
	modport source (output valid, is_snp, snp_pos, snp_score, done_res, input ready);
	modport sink (input valid, is_snp, snp_pos, snp_score, done_res, output ready);
endinterface

interface snpcns_cfg_if;
	logic valid;
	logic ready;
	logic [snpcns_pkg::IDX_W-1:0] idx;
	logic [snpcns_pkg::POS_W-1:0] data;
	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

>>> hdl/snpcns_fifo.sv
// four-entry queue of classified position records between front and back
// depends on snpcns_pkg
`timescale 1ns / 1ps
module snpcns_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  snpcns_pkg::rec_t wdata,
	output logic full,
	input  logic pop,
	output snpcns_pkg::rec_t rdata,
	output logic empty
);
	snpcns_pkg::rec_t mem_q [snpcns_pkg::FIFO_DEPTH];
	logic [snpcns_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [snpcns_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [snpcns_pkg::FIFO_CW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == snpcns_pkg::FIFO_CW'(snpcns_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

>>> hdl/snpcns_front.sv
// front: takes items, forms the combined score, flags snps, keeps the window
// depends on snpcns_pkg and snpcns_if
`timescale 1ns / 1ps
module snpcns_front (
	input  logic clk,
	input  logic arst_n,
	input  snpcns_pkg::cfg_t cfg,
	snpcns_item_if.sink items,
	output logic push,
	output snpcns_pkg::rec_t rec,
	input  logic full
);
	logic valid_s1;
	logic [snpcns_pkg::PROD_W-1:0] prod_s1;
	logic [snpcns_pkg::SCORE_W-1:0] q1_s1;
	logic last_s1;
	logic [snpcns_pkg::POS_W-1:0] pos_q;
	logic [1:0] items_seen_q;
	logic [3:0] fd_q;
	logic [snpcns_pkg::SCORE_W-1:0] sd0_q;
	logic [snpcns_pkg::SCORE_W-1:0] sd1_q;
	logic advance;
	logic take;
	logic [snpcns_pkg::PROD_W-snpcns_pkg::FRAC_W-1:0] prod_sh;
	logic [snpcns_pkg::SCORE_W-1:0] capped;
	logic [snpcns_pkg::SCORE_W-1:0] comb;
	logic f;
	logic [snpcns_pkg::POS_W-1:0] cur_pos;

	assign advance = valid_s1 && !full;
	assign items.ready = !valid_s1 || advance;
	assign take = items.valid && items.ready;

	always_comb begin
		prod_sh = prod_s1[snpcns_pkg::PROD_W-1:snpcns_pkg::FRAC_W];
		if (prod_sh > {8'd0, snpcns_pkg::CAP_Q}) begin
			capped = snpcns_pkg::CAP_Q;
		end else begin
			capped = prod_sh[snpcns_pkg::SCORE_W-1:0];
		end
		comb = cfg.pair_mode ? capped : q1_s1;
		f = (comb >= {cfg.cutoff, 8'd0});
		cur_pos = (items_seen_q == 2'd0) ? cfg.start_pos : pos_q;
	end

	assign push = advance;
	assign rec = '{pos: cur_pos, comb: comb, f: f, last: last_s1, fd: fd_q,
		sd0: sd0_q, sd1: sd1_q};

	always_ff @(posedge clk) begin
		if (take) begin
			prod_s1 <= snpcns_pkg::PROD_W'(items.q_primary) *
				snpcns_pkg::PROD_W'(items.q_secondary);
			q1_s1 <= items.q_primary;
			last_s1 <= items.region_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q <= '0;
			items_seen_q <= '0;
			fd_q <= '0;
			sd0_q <= '0;
			sd1_q <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				pos_q <= cur_pos + 1'b1;
				if (last_s1) begin
					items_seen_q <= '0;
					fd_q <= '0;
					sd0_q <= '0;
					sd1_q <= '0;
				end else begin
					if (items_seen_q != 2'd3) begin
						items_seen_q <= items_seen_q + 1'b1;
					end
					fd_q <= {fd_q[2:0], f};
					sd1_q <= sd0_q;
					sd0_q <= comb;
				end
			end
		end
	end
endmodule

>>> hdl/snpcns_back.sv
// back: expands records into results, reduces scores with a shared divider
// depends on snpcns_pkg and snpcns_if
`timescale 1ns / 1ps
module snpcns_back (
	input  logic clk,
	input  logic arst_n,
	output logic pop,
	input  snpcns_pkg::rec_t rec,
	input  logic empty,
	snpcns_result_if.source results
);
	snpcns_pkg::div_state_t div_q;
	snpcns_pkg::div_state_t div_nx;
	snpcns_pkg::rec_t rec_q;
	logic rec_valid_q;
	logic [2:0] pend_q;
	logic mark_q;
	logic [snpcns_pkg::DIV_W-1:0] dvd_q;
	logic [snpcns_pkg::DIV_W-1:0] quo_q;
	logic [snpcns_pkg::COST_W-1:0] rem_q;
	logic [snpcns_pkg::COST_W-1:0] cost_q;
	logic [snpcns_pkg::CNT_W-1:0] cnt_q;
	logic [snpcns_pkg::POS_W-1:0] jpos_q;
	logic jdone_q;
	logic out_valid_q;
	logic out_snp_q;
	logic [snpcns_pkg::POS_W-1:0] out_pos_q;
	logic [snpcns_pkg::SCORE_W-1:0] out_score_q;
	logic out_done_q;
	logic out_free;
	logic start;
	logic emit_mark;
	logic release_rec;
	logic out_load;
	logic [2:0] sel;
	logic [snpcns_pkg::SCORE_W-1:0] j_score;
	logic [snpcns_pkg::POS_W-1:0] j_pos;
	logic [1:0] j_near;
	logic [1:0] j_far;
	logic [snpcns_pkg::COST_W-1:0] j_cost;
	logic [snpcns_pkg::SCORE_W+1:0] j_x3;
	logic [snpcns_pkg::COST_W-1:0] rem_nx;
	logic [snpcns_pkg::DIV_W-1:0] dvd_nx;
	logic [snpcns_pkg::DIV_STEP-1:0] qbits;

	assign out_free = !out_valid_q || results.ready;

	// job selection, lowest pending result first
	always_comb begin
		if (pend_q[0]) begin
			sel = 3'b001;
		end else if (pend_q[1]) begin
			sel = 3'b010;
		end else begin
			sel = 3'b100;
		end
		case (sel)
			3'b001: begin
				j_score = rec_q.sd1;
				j_pos = rec_q.pos - 2'd2;
				j_near = {1'b0, rec_q.fd[2]} + {1'b0, rec_q.fd[0]};
				j_far = {1'b0, rec_q.fd[3]} + {1'b0, rec_q.f};
			end
			3'b010: begin
				j_score = rec_q.sd0;
				j_pos = rec_q.pos - 1'b1;
				j_near = {1'b0, rec_q.fd[1]} + {1'b0, rec_q.f};
				j_far = {1'b0, rec_q.fd[2]};
			end
			default: begin
				j_score = rec_q.comb;
				j_pos = rec_q.pos;
				j_near = {1'b0, rec_q.fd[0]};
				j_far = {1'b0, rec_q.fd[1]};
			end
		endcase
		j_cost = 4'd3 + {1'b0, j_near, 1'b0} + {2'b00, j_far};
		j_x3 = {1'b0, j_score, 1'b0} + {2'b00, j_score};
	end

	// four restoring steps per cycle
	always_comb begin
		logic [snpcns_pkg::COST_W:0] r;
		logic [snpcns_pkg::DIV_W-1:0] d;
		r = {1'b0, rem_q};
		d = dvd_q;
		qbits = '0;
		for (int k = 0; k < snpcns_pkg::DIV_STEP; k++) begin
			r = {r[snpcns_pkg::COST_W-1:0], d[snpcns_pkg::DIV_W-1]};
			d = {d[snpcns_pkg::DIV_W-2:0], 1'b0};
			if (r >= {1'b0, cost_q}) begin
				r = r - {1'b0, cost_q};
				qbits[snpcns_pkg::DIV_STEP-1-k] = 1'b1;
			end
		end
		rem_nx = r[snpcns_pkg::COST_W-1:0];
		dvd_nx = d;
	end

	always_comb begin
		div_nx = div_q;
		start = 1'b0;
		emit_mark = 1'b0;
		out_load = 1'b0;
		case (div_q)
			snpcns_pkg::DIV_IDLE: begin
				if (rec_valid_q && pend_q != 3'b000) begin
					start = 1'b1;
					div_nx = snpcns_pkg::DIV_RUN;
				end else if (rec_valid_q && mark_q && out_free) begin
					emit_mark = 1'b1;
				end
			end
			snpcns_pkg::DIV_RUN: begin
				if (cnt_q == snpcns_pkg::CNT_W'(snpcns_pkg::DIV_CYC - 1)) begin
					div_nx = snpcns_pkg::DIV_HOLD;
				end
			end
			snpcns_pkg::DIV_HOLD: begin
				if (out_free) begin
					out_load = 1'b1;
					div_nx = snpcns_pkg::DIV_IDLE;
				end
			end
			default: begin
				div_nx = snpcns_pkg::DIV_IDLE;
			end
		endcase
		release_rec = rec_valid_q && pend_q == 3'b000 && !mark_q;
		pop = (!rec_valid_q || release_rec) && !empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= snpcns_pkg::DIV_IDLE;
		end else begin
			div_q <= div_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= rec;
		end
		if (start) begin
			dvd_q <= {2'b00, j_x3};
			cost_q <= j_cost;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			jpos_q <= j_pos;
			jdone_q <= rec_q.last && ((pend_q & ~sel) == 3'b000);
		end else if (div_q == snpcns_pkg::DIV_RUN) begin
			dvd_q <= dvd_nx;
			rem_q <= rem_nx;
			quo_q <= {quo_q[snpcns_pkg::DIV_W-snpcns_pkg::DIV_STEP-1:0], qbits};
			cnt_q <= cnt_q + 1'b1;
		end
		if (out_load) begin
			out_snp_q <= 1'b1;
			out_pos_q <= jpos_q;
			out_score_q <= quo_q[snpcns_pkg::SCORE_W-1:0];
			out_done_q <= jdone_q;
		end else if (emit_mark) begin
			out_snp_q <= 1'b0;
			out_pos_q <= '0;
			out_score_q <= '0;
			out_done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
			pend_q <= '0;
			mark_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				rec_valid_q <= 1'b1;
				pend_q <= {rec.last & rec.f, rec.last & rec.fd[0], rec.fd[1]};
				mark_q <= rec.last & !rec.f & !rec.fd[0] & !rec.fd[1];
			end else begin
				if (release_rec) begin
					rec_valid_q <= 1'b0;
				end
				if (start) begin
					pend_q <= pend_q & ~sel;
				end
				if (emit_mark) begin
					mark_q <= 1'b0;
				end
			end
			if (out_load || emit_mark) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid = out_valid_q;
	assign results.is_snp = out_snp_q;
	assign results.snp_pos = out_pos_q;
	assign results.snp_score = out_score_q;
	assign results.done_res = out_done_q;
endmodule

>>> hdl/snp_candidate_neighbour_scoring_core.sv
// snp candidate scoring with neighbour reduction, top level
// Channels: items (q_primary, q_secondary, region_end), results (is_snp,
// snp_pos, snp_score, done_res), cfg (idx, data) for cutoff, pair_mode
// and start_pos; every channel is valid/ready, a transfer when both high.
// A position's results appear once the item two places later arrives, or
// when the region_end item flushes the window; a region_end item with no
// snp gives one marker result with is_snp low and done_res high.
// The front takes one item per cycle unless the queue is full: a register
// stage holds the product, then the item is flagged and queued in a
// four-entry record queue. The back holds one record at a time; records
// without results are released without the divider, and each snp result
// waits for the shared divider, which reduces the score four quotient bits
// per cycle.
// Reset clears the window, position count, queue and output valid flag and
// loads the register defaults (cutoff 40, pair_mode 0, start_pos 1).
// When the receiver stalls the result is held in the output register, the
// divider and queue fill, and items ready falls once the queue is full.
// Register writes are always accepted; write them only while idle.
`timescale 1ns / 1ps
`include "snp_candidate_neighbour_scoring_core_defines.svh"
module snp_candidate_neighbour_scoring_core (
	input  logic clk,
	input  logic arst_n,
	snpcns_item_if.sink items,
	snpcns_result_if.source results,
	snpcns_cfg_if.sink cfg
);
	snpcns_pkg::cfg_t cfg_q;
	snpcns_pkg::rec_t push_rec;
	snpcns_pkg::rec_t pop_rec;
	logic push;
	logic pop;
	logic full;
	logic empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cutoff <= 12'd40;
			cfg_q.pair_mode <= 1'b0;
			cfg_q.start_pos <= 24'd1;
		end else if (cfg.valid) begin
			case (cfg.idx)
				snpcns_pkg::REG_CUTOFF: begin
					cfg_q.cutoff <= cfg.data[snpcns_pkg::CUT_W-1:0];
				end
				snpcns_pkg::REG_PAIR_MODE: begin
					cfg_q.pair_mode <= cfg.data[0];
				end
				snpcns_pkg::REG_START_POS: begin
					cfg_q.start_pos <= cfg.data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	snpcns_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.items(items),
		.push(push),
		.rec(push_rec),
		.full(full)
	);

	snpcns_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(push_rec),
		.full(full),
		.pop(pop),
		.rdata(pop_rec),
		.empty(empty)
	);

	snpcns_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop(pop),
		.rec(pop_rec),
		.empty(empty),
		.results(results)
	);

	`SNPCNS_ASSERT_NEVER(a_queue_full_empty, full && empty)
	`SNPCNS_ASSERT_IMP(a_marker_done, results.valid && !results.is_snp, results.done_res)
	`SNPCNS_ASSERT_IMP(a_marker_zero, results.valid && !results.is_snp,
		results.snp_pos == '0 && results.snp_score == '0)
	`SNPCNS_ASSERT_NEVER(a_push_when_full, push && full)
endmodule
